### src/bqf_pkg.sv
// Shared types and constants for the six-channel biquad filter.
// No dependencies; imported by every module of the block.
package bqf_pkg;

  localparam int CHANNELS        = 6;
  localparam int COEF_W          = 20;
  localparam int SAMPLE_W_DEF    = 32;
  localparam int COEF_FRAC_DEF   = 16;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 5;

  // Reset coefficients, Q4.16
  localparam logic signed [COEF_W-1:0] B0_RST = 20'sd1317;
  localparam logic signed [COEF_W-1:0] B1_RST = 20'sd2635;
  localparam logic signed [COEF_W-1:0] B2_RST = 20'sd1317;
  localparam logic signed [COEF_W-1:0] A1_RST = -20'sd102303;
  localparam logic signed [COEF_W-1:0] A2_RST = 20'sd42035;

  // Register word index (byte address / 4)
  typedef enum logic [APB_ADDR_W-3:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  // Pipeline strobes from the control to every lane
  typedef struct packed {
    logic acc;   // item accepted into stage 1
    logic ld2;   // stage 1 moves into stage 2
    logic fire;  // stage 2 completes into the output register
  } pipe_ctl_t;

endpackage

### src/bqf_cfg.sv
// APB coefficient register file for the biquad filter.
// Depends on bqf_pkg.
module bqf_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bqf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bqf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bqf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output bqf_pkg::coef_t                    coef_o
);
  import bqf_pkg::*;

  coef_t                    coef_q;
  logic [APB_ADDR_W-3:0]    idx;
  logic                     wr_en;
  logic signed [COEF_W-1:0] rd_coef;
  logic                     rd_hit;

  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign coef_o = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= B0_RST;
      coef_q.b1 <= B1_RST;
      coef_q.b2 <= B2_RST;
      coef_q.a1 <= A1_RST;
      coef_q.a2 <= A2_RST;
    end else if (wr_en) begin
      case (idx)
        REG_B0:  coef_q.b0 <= pwdata[COEF_W-1:0];
        REG_B1:  coef_q.b1 <= pwdata[COEF_W-1:0];
        REG_B2:  coef_q.b2 <= pwdata[COEF_W-1:0];
        REG_A1:  coef_q.a1 <= pwdata[COEF_W-1:0];
        REG_A2:  coef_q.a2 <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_coef = '0;
    rd_hit  = 1'b1;
    case (idx)
      REG_B0:  rd_coef = coef_q.b0;
      REG_B1:  rd_coef = coef_q.b1;
      REG_B2:  rd_coef = coef_q.b2;
      REG_A1:  rd_coef = coef_q.a1;
      REG_A2:  rd_coef = coef_q.a2;
      default: rd_hit  = 1'b0;
    endcase
  end

  // sign-extended read-back, zero for unmapped words
  assign prdata = rd_hit ? {{(APB_DATA_W-COEF_W){rd_coef[COEF_W-1]}}, rd_coef} : '0;

endmodule

### src/bqf_ctrl.sv
// Valid/ready pipeline control shared by all filter lanes.
// Depends on bqf_pkg.
module bqf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bqf_pkg::pipe_ctl_t ctl_o
);
  import bqf_pkg::*;

  logic v1_q, v2_q, ov_q;
  logic en_out, en2, en1, acc;

  // each stage moves when the one after it is empty or moving
  assign en_out = !ov_q || out_ready_i;
  assign en2    = !v2_q || en_out;
  assign en1    = !v1_q || en2;
  assign acc    = in_valid_i && en1;

  assign in_ready_o  = en1;
  assign out_valid_o = ov_q;

  assign ctl_o.acc  = acc;
  assign ctl_o.ld2  = en2 && v1_q;
  assign ctl_o.fire = en_out && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= acc;
      if (en2)    v2_q <= v1_q;
      if (en_out) ov_q <= v2_q;
    end
  end

endmodule

### src/bqf_lane.sv
// One channel of the direct-form-I biquad: products, partial sum, feedback stage.
// Depends on bqf_pkg; strobes come from bqf_ctrl.
module bqf_lane #(
  parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bqf_pkg::coef_t                 coef_i,
  input  bqf_pkg::pipe_ctl_t             ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_i,
  output logic signed [SAMPLE_WIDTH-1:0] y_o
);
  import bqf_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + 4;
  localparam int SHW    = ACC_W - COEF_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;

  logic signed [SAMPLE_WIDTH-1:0] x1_q, x2_q, y1_q, y2_q;
  logic signed [PROD_W-1:0]       pb0_q, pb1_q, pb2_q, m2_q;
  logic signed [PROD_W-1:0]       pb0_d, pb1_d, pb2_d, m2_d, a1y;
  logic signed [ACC_W-1:0]        sum_q, sum_d, acc, acc_sh;
  logic signed [SAMPLE_WIDTH-1:0] m2_sel, y_d;
  logic [SHW-SAMPLE_WIDTH:0]      hi;
  logic [SHW-1:0]                 sh;

  assign b0 = coef_i.b0;
  assign b1 = coef_i.b1;
  assign b2 = coef_i.b2;
  assign a1 = coef_i.a1;
  assign a2 = coef_i.a2;

  // stage 1: feedforward products
  assign pb0_d = x_i  * b0;
  assign pb1_d = x1_q * b1;
  assign pb2_d = x2_q * b2;

  // stage 2: feedforward sum plus rounding offset
  assign sum_d = ACC_W'(pb0_q) + ACC_W'(pb1_q) + ACC_W'(pb2_q) + HALF;

  // a2*y[n-2] is kept ready ahead of the item that needs it: on a completion the
  // old y[n-1] becomes the next item's y[n-2], otherwise y2 already is.
  assign m2_sel = ctl_i.fire ? y1_q : y2_q;
  assign m2_d   = m2_sel * a2;

  // feedback stage: one multiply, subtract, round, clamp
  assign a1y    = y1_q * a1;
  assign acc    = sum_q - ACC_W'(m2_q) - ACC_W'(a1y);
  assign acc_sh = acc >>> COEF_FRAC_BITS;
  assign sh     = acc_sh[SHW-1:0];
  assign hi     = sh[SHW-1:SAMPLE_WIDTH-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      y_d = sh[SAMPLE_WIDTH-1:0];
    end else if (hi[SHW-SAMPLE_WIDTH]) begin
      y_d = Y_MIN;
    end else begin
      y_d = Y_MAX;
    end
  end

  assign y_o = y1_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      pb0_q <= pb0_d;
      pb1_q <= pb1_d;
      pb2_q <= pb2_d;
    end
    if (ctl_i.ld2) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
      m2_q <= '0;
    end else begin
      if (ctl_i.acc) begin
        x1_q <= x_i;
        x2_q <= x1_q;
      end
      if (ctl_i.fire) begin
        y1_q <= y_d;
        y2_q <= y1_q;
      end
      m2_q <= m2_d;
    end
  end

endmodule

### src/six_channel_biquad_filter.sv
// Six-channel biquad low-pass filter: top level with APB coefficients and lanes.
// Depends on bqf_pkg, bqf_cfg, bqf_ctrl and bqf_lane.
//
// Each item carries one velocity sample (linear x/y/z, angular x/y/z, signed Q16.16);
// each component runs through its own direct-form-I biquad
//   y[n] = b0*x[n] + b1*x[n-1] + b2*x[n-2] - a1*y[n-1] - a2*y[n-2]
// with one shared set of Q4.16 coefficients, summed exactly, rounded half-up once
// and clamped to the sample range; the clamped value is what is fed back. All six
// lanes work in parallel and the result is one item of six components. Throughput
// is one item per clock unless the output stalls; an accepted item passes product,
// sum and output registers before out_valid_o rises. Each lane's feedback stage sets
// the rate: the a1*y[n-1] multiply, add, round and clamp feed y[n-1] combinationally
// for the next item, and a2*y[n-2] is registered ahead of need. Input and output
// each have their own valid/ready and the pipeline keeps accepting while a result
// waits to be taken, until all stages are full. Coefficients sit at byte addresses
// 0x00 b0, 0x04 b1, 0x08 b2, 0x0C a1, 0x10 a2 (20 bits, sign-extended on read) and
// may only be written while no item is in flight. Filter history clears on reset.
module six_channel_biquad_filter #(
  parameter int SAMPLE_WIDTH   = bqf_pkg::SAMPLE_W_DEF,
  parameter int COEF_FRAC_BITS = bqf_pkg::COEF_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bqf_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [bqf_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [bqf_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]  lin_x_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  lin_y_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  lin_z_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  ang_x_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  ang_y_in_i,
  input  logic signed [SAMPLE_WIDTH-1:0]  ang_z_in_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]  lin_x_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  lin_y_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  lin_z_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  ang_x_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  ang_y_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]  ang_z_out_o
);
  import bqf_pkg::*;

  coef_t                          coef;
  pipe_ctl_t                      ctl;
  logic signed [SAMPLE_WIDTH-1:0] x   [CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] y   [CHANNELS];

  bqf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  bqf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl)
  );

  // lane order follows the item: linear x, y, z then angular x, y, z
  assign x[0] = lin_x_in_i;
  assign x[1] = lin_y_in_i;
  assign x[2] = lin_z_in_i;
  assign x[3] = ang_x_in_i;
  assign x[4] = ang_y_in_i;
  assign x[5] = ang_z_in_i;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    bqf_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .coef_i (coef),
      .ctl_i  (ctl),
      .x_i    (x[g]),
      .y_o    (y[g])
    );
  end

  // each lane's y[n-1] register doubles as its slice of the output register
  assign lin_x_out_o = y[0];
  assign lin_y_out_o = y[1];
  assign lin_z_out_o = y[2];
  assign ang_x_out_o = y[3];
  assign ang_y_out_o = y[4];
  assign ang_z_out_o = y[5];

endmodule
